FILE: src/wefd_pkg.sv
package wefd_pkg;

    // Largest frame the byte counter tracks before it saturates.
    localparam int MAX_FRAME_BYTES = 4096;
    localparam int IDX_W           = 12;
    localparam int IDX_LIMIT_INT   = (MAX_FRAME_BYTES - 1 < 4095) ? MAX_FRAME_BYTES - 1 : 4095;
    localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_LIMIT_INT[IDX_W-1:0];

    // Field widths of the request and the result.
    localparam int BYTE_W = 8;
    localparam int MAC_W  = 48;
    localparam int LEN_W  = 12;
    localparam int HDR_W  = 6;

    localparam logic [LEN_W-1:0] BODY_MAX = {LEN_W{1'b1}};

    // Frame control bits, with the second byte in the upper half.
    localparam logic [15:0] FC_QOS   = 16'h0080;
    localparam logic [15:0] FC_TO_DS = 16'h0100;
    localparam logic [15:0] FC_FR_DS = 16'h0200;
    localparam logic [15:0] FC_ORDER = 16'h8000;

    // Header lengths in bytes.
    localparam logic [HDR_W-1:0] HDR_BASE  = 6'd24;
    localparam logic [HDR_W-1:0] HDR_ADDR4 = 6'd6;
    localparam logic [HDR_W-1:0] HDR_QOS   = 6'd2;
    localparam logic [HDR_W-1:0] HDR_HTC   = 6'd4;

    // Byte positions of the three captured addresses.
    localparam logic [IDX_W-1:0] ADDR1_FIRST = 12'd4;
    localparam logic [IDX_W-1:0] ADDR2_FIRST = 12'd10;
    localparam logic [IDX_W-1:0] ADDR3_FIRST = 12'd16;
    localparam logic [IDX_W-1:0] ADDR3_END   = 12'd22;

    localparam logic [IDX_W-1:0] SNAP_LEN  = 12'd8;
    localparam logic [2:0]       SNAP_LAST = 3'd7;

    // LLC/SNAP bytes that announce an EAPOL payload.
    localparam logic [BYTE_W-1:0] LLC_SAP      = 8'hAA;
    localparam logic [BYTE_W-1:0] LLC_CTRL_UI  = 8'h03;
    localparam logic [BYTE_W-1:0] SNAP_OUI     = 8'h00;
    localparam logic [BYTE_W-1:0] ETYPE_HIGH   = 8'h88;
    localparam logic [BYTE_W-1:0] ETYPE_LOW    = 8'h8E;

    // Expected byte at each position of the SNAP header.
    function automatic logic [BYTE_W-1:0] snap_byte(input logic [2:0] pos);
        logic [BYTE_W-1:0] val;
        unique case (pos)
            3'd0, 3'd1:       val = LLC_SAP;
            3'd2:             val = LLC_CTRL_UI;
            3'd3, 3'd4, 3'd5: val = SNAP_OUI;
            3'd6:             val = ETYPE_HIGH;
            default:          val = ETYPE_LOW;
        endcase
        return val;
    endfunction

    // Length of the MAC header from the frame control word.
    function automatic logic [HDR_W-1:0] header_length(input logic [15:0] fc);
        logic             qos;
        logic [HDR_W-1:0] len;
        qos = (fc & FC_QOS) != 16'h0;
        len = HDR_BASE;
        if (((fc & FC_TO_DS) != 16'h0) && ((fc & FC_FR_DS) != 16'h0)) begin
            len = len + HDR_ADDR4;
        end
        if (qos) begin
            len = len + HDR_QOS;
        end
        if (qos && ((fc & FC_ORDER) != 16'h0)) begin
            len = len + HDR_HTC;
        end
        return len;
    endfunction

endpackage

FILE: src/wefd_req_if.sv
interface wefd_req_if;
    logic                              valid;
    logic                              ready;
    logic [wefd_pkg::BYTE_W-1:0]       data_byte;
    logic                              frame_start;
    logic                              frame_end;
    logic signed [wefd_pkg::BYTE_W-1:0] signal_dbm;

    modport source (
        output valid, data_byte, frame_start, frame_end, signal_dbm,
        input  ready
    );
    modport sink (
        input  valid, data_byte, frame_start, frame_end, signal_dbm,
        output ready
    );
endinterface

FILE: src/wefd_res_if.sv
interface wefd_res_if;
    logic                               valid;
    logic                               ready;
    logic [wefd_pkg::BYTE_W-1:0]        body_byte;
    logic                               body_valid;
    logic                               frame_done;
    logic                               is_eapol;
    logic [wefd_pkg::MAC_W-1:0]         source_mac;
    logic [wefd_pkg::MAC_W-1:0]         dest_mac;
    logic [wefd_pkg::MAC_W-1:0]         bss_id;
    logic signed [wefd_pkg::BYTE_W-1:0] frame_signal;
    logic [wefd_pkg::LEN_W-1:0]         body_length;

    modport source (
        output valid, body_byte, body_valid, frame_done, is_eapol, source_mac,
               dest_mac, bss_id, frame_signal, body_length,
        input  ready
    );
    modport sink (
        input  valid, body_byte, body_valid, frame_done, is_eapol, source_mac,
               dest_mac, bss_id, frame_signal, body_length,
        output ready
    );
endinterface

FILE: src/wlan_eapol_frame_detector_core.sv
// A result is registered: it is written into the output register when its byte is accepted.
// Throughput: one byte per cycle; a byte is taken whenever the output register is empty
// or its result is taken in the same cycle, so the result register is the only stage.
// A byte gives a result only when it is a forwarded body byte or the frame's last byte.
// Reset (synchronous, active low) clears the frame tracking, the latched signal
// strength and the output valid; address and result payload registers are not reset.
module wlan_eapol_frame_detector_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wefd_req_if.sink    i_req,
    wefd_res_if.source  o_res
);

    // Per-frame tracking state.
    logic [wefd_pkg::IDX_W-1:0]         r_byte_index, n_byte_index;
    logic [wefd_pkg::BYTE_W-1:0]        r_fc_low, n_fc_low;
    logic [wefd_pkg::HDR_W-1:0]         r_snap_start, n_snap_start;
    logic                               r_snap_good, n_snap_good;
    logic                               r_match_seen, n_match_seen;
    logic [wefd_pkg::MAC_W-1:0]         r_addr_one, n_addr_one;
    logic [wefd_pkg::MAC_W-1:0]         r_addr_two, n_addr_two;
    logic [wefd_pkg::MAC_W-1:0]         r_addr_three, n_addr_three;
    logic signed [wefd_pkg::BYTE_W-1:0] r_signal, n_signal;
    logic [wefd_pkg::LEN_W-1:0]         r_body_count, n_body_count;

    // Result register.
    logic                               r_out_valid, n_out_valid;
    logic [wefd_pkg::BYTE_W-1:0]        r_body_byte;
    logic                               r_body_valid;
    logic                               r_frame_done;
    logic                               r_is_eapol;
    logic [wefd_pkg::MAC_W-1:0]         r_source_mac;
    logic [wefd_pkg::MAC_W-1:0]         r_dest_mac;
    logic [wefd_pkg::MAC_W-1:0]         r_bss_id;
    logic signed [wefd_pkg::BYTE_W-1:0] r_frame_signal;
    logic [wefd_pkg::LEN_W-1:0]         r_body_length;

    logic                               req_accept;
    logic                               res_accept;
    logic                               make_result;
    logic                               fwd_body;

    // Frame state as seen by this byte, after a start mark has cleared it.
    logic [wefd_pkg::IDX_W-1:0]         c_idx;
    logic [wefd_pkg::HDR_W-1:0]         c_snap_start;
    logic                               c_snap_good;
    logic                               c_match;
    logic [wefd_pkg::LEN_W-1:0]         c_body_count;
    logic [wefd_pkg::HDR_W-1:0]         snap_start_now;
    logic [wefd_pkg::IDX_W-1:0]         snap_lo;
    logic [wefd_pkg::IDX_W-1:0]         snap_off;
    logic                               in_snap;
    logic                               snap_good_now;
    logic                               match_now;
    logic [wefd_pkg::LEN_W-1:0]         body_count_now;

    assign res_accept  = r_out_valid && o_res.ready;
    assign i_req.ready = !r_out_valid || o_res.ready;
    assign req_accept  = i_req.valid && i_req.ready;

    // Apply a start mark before the byte itself is looked at.
    always_comb begin
        if (i_req.frame_start) begin
            c_idx        = '0;
            c_snap_start = wefd_pkg::HDR_BASE;
            c_snap_good  = 1'b1;
            c_match      = 1'b0;
            c_body_count = '0;
            n_signal     = i_req.signal_dbm;
        end else begin
            c_idx        = r_byte_index;
            c_snap_start = r_snap_start;
            c_snap_good  = r_snap_good;
            c_match      = r_match_seen;
            c_body_count = r_body_count;
            n_signal     = r_signal;
        end
    end

    // Frame control capture and header length.
    always_comb begin
        n_fc_low       = r_fc_low;
        snap_start_now = c_snap_start;
        if (c_idx == 12'd0) begin
            n_fc_low = i_req.data_byte;
        end else if (c_idx == 12'd1) begin
            snap_start_now = wefd_pkg::header_length({i_req.data_byte, r_fc_low});
        end
    end

    // Address capture by byte position, first byte most significant.
    always_comb begin
        n_addr_one   = r_addr_one;
        n_addr_two   = r_addr_two;
        n_addr_three = r_addr_three;
        if (c_idx >= wefd_pkg::ADDR1_FIRST && c_idx < wefd_pkg::ADDR2_FIRST) begin
            n_addr_one = {r_addr_one[wefd_pkg::MAC_W-wefd_pkg::BYTE_W-1:0], i_req.data_byte};
        end else if (c_idx >= wefd_pkg::ADDR2_FIRST && c_idx < wefd_pkg::ADDR3_FIRST) begin
            n_addr_two = {r_addr_two[wefd_pkg::MAC_W-wefd_pkg::BYTE_W-1:0], i_req.data_byte};
        end else if (c_idx >= wefd_pkg::ADDR3_FIRST && c_idx < wefd_pkg::ADDR3_END) begin
            n_addr_three = {r_addr_three[wefd_pkg::MAC_W-wefd_pkg::BYTE_W-1:0],
                            i_req.data_byte};
        end
    end

    // SNAP header compare and body forwarding.
    always_comb begin
        snap_lo        = {{(wefd_pkg::IDX_W-wefd_pkg::HDR_W){1'b0}}, snap_start_now};
        snap_off       = c_idx - snap_lo;
        in_snap        = (c_idx >= snap_lo) && (c_idx < snap_lo + wefd_pkg::SNAP_LEN);
        snap_good_now  = c_snap_good;
        match_now      = c_match;
        body_count_now = c_body_count;
        fwd_body       = 1'b0;
        if (c_match) begin
            fwd_body = 1'b1;
            if (c_body_count != wefd_pkg::BODY_MAX) begin
                body_count_now = c_body_count + 12'd1;
            end
        end else if (in_snap) begin
            if (i_req.data_byte != wefd_pkg::snap_byte(snap_off[2:0])) begin
                snap_good_now = 1'b0;
            end
            if (snap_off[2:0] == wefd_pkg::SNAP_LAST && snap_good_now) begin
                match_now = 1'b1;
            end
        end
        make_result = fwd_body || i_req.frame_end;
    end

    // Next frame state; the last byte returns it to the idle values.
    always_comb begin
        if (i_req.frame_end) begin
            n_byte_index = '0;
            n_snap_start = wefd_pkg::HDR_BASE;
            n_snap_good  = 1'b1;
            n_match_seen = 1'b0;
            n_body_count = '0;
        end else begin
            n_byte_index = (c_idx < wefd_pkg::IDX_LIMIT) ? c_idx + 12'd1 : c_idx;
            n_snap_start = snap_start_now;
            n_snap_good  = snap_good_now;
            n_match_seen = match_now;
            n_body_count = body_count_now;
        end
    end

    // Output valid: set by a new result, cleared when the result is taken.
    always_comb begin
        n_out_valid = r_out_valid && !res_accept;
        if (req_accept && make_result) begin
            n_out_valid = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
            r_fc_low     <= '0;
            r_snap_start <= wefd_pkg::HDR_BASE;
            r_snap_good  <= 1'b1;
            r_match_seen <= 1'b0;
            r_signal     <= '0;
            r_body_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (req_accept) begin
                r_byte_index <= n_byte_index;
                r_fc_low     <= n_fc_low;
                r_snap_start <= n_snap_start;
                r_snap_good  <= n_snap_good;
                r_match_seen <= n_match_seen;
                r_signal     <= n_signal;
                r_body_count <= n_body_count;
            end
        end
    end

    // Address and result payload registers.
    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_addr_one   <= n_addr_one;
            r_addr_two   <= n_addr_two;
            r_addr_three <= n_addr_three;
        end
        if (req_accept && make_result) begin
            r_body_byte    <= fwd_body ? i_req.data_byte : '0;
            r_body_valid   <= fwd_body;
            r_frame_done   <= i_req.frame_end;
            r_is_eapol     <= match_now;
            r_source_mac   <= match_now ? n_addr_two : '0;
            r_dest_mac     <= match_now ? n_addr_one : '0;
            r_bss_id       <= match_now ? n_addr_three : '0;
            r_frame_signal <= n_signal;
            r_body_length  <= match_now ? body_count_now : '0;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.body_byte    = r_body_byte;
    assign o_res.body_valid   = r_body_valid;
    assign o_res.frame_done   = r_frame_done;
    assign o_res.is_eapol     = r_is_eapol;
    assign o_res.source_mac   = r_source_mac;
    assign o_res.dest_mac     = r_dest_mac;
    assign o_res.bss_id       = r_bss_id;
    assign o_res.frame_signal = r_frame_signal;
    assign o_res.body_length  = r_body_length;

    // A match can only stand while the SNAP compare is still good.
    a_match_implies_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_match_seen |-> r_snap_good)
        else $error("match flag set with a failed SNAP compare");

    // Every result is either a body byte or a frame summary.
    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_body_valid || r_frame_done))
        else $error("result with neither body byte nor frame end");

    // Body bytes and a body count are only reported for a matched frame.
    a_body_needs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_body_valid || r_body_length != '0)) |-> r_is_eapol)
        else $error("body reported for a frame without a SNAP match");

    // The last byte of a frame returns the tracking state to idle.
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_accept && i_req.frame_end) |=>
            (r_byte_index == '0 && !r_match_seen && r_body_count == '0))
        else $error("frame state not cleared after the last byte");

    // The byte counter never passes its saturation limit.
    a_index_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_index <= wefd_pkg::IDX_LIMIT)
        else $error("byte index beyond its limit");

endmodule
